### rtl/core/fds_pkg.sv
`timescale 1ns / 1ps

package fds_pkg;

  localparam int SECTOR_BYTES_DEF = 512;
  localparam int ENTRY_BYTES      = 32;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [7:0] ATTR_LONG_NAME = 8'h0f;
  localparam logic [7:0] NAME_DELETED_A = 8'h05;
  localparam logic [7:0] NAME_DELETED_B = 8'he5;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_DOT       = 8'h2e;
  localparam logic [7:0] CHAR_NUL       = 8'h00;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SHIFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_SECTOR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_CLUSTER_NR = 2'd2;

  localparam logic [27:0] ROOT_CLUSTER_RESET = 28'd2;

  // one unit of work handed from the front to the back
  typedef struct packed {
    logic        is_end;
    logic [63:0] base;
    logic [23:0] ext;
    logic [3:0]  base_len;
    logic [1:0]  ext_len;
    logic [7:0]  attr;
    logic [31:0] start;
    logic [31:0] size;
    logic [31:0] esec;
  } job_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  name_char;
    logic [7:0]  attr;
    logic [31:0] start;
    logic [31:0] size;
    logic [31:0] esec;
    logic        last;
  } result_t;

endpackage

### rtl/core/fds_front.sv
`timescale 1ns / 1ps

module fds_front import fds_pkg::*; #(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        restart_i,
  input  logic [63:0] name_base_i,
  input  logic [23:0] name_ext_i,
  input  logic [7:0]  attr_in_i,
  input  logic [15:0] cluster_high_i,
  input  logic [15:0] cluster_low_i,
  input  logic [31:0] file_bytes_i,
  input  logic [2:0]  cluster_shift_i,
  input  logic [31:0] root_sector_i,
  input  logic [27:0] root_cluster_i,
  input  logic        full_i,
  output logic        push_o,
  output job_t        job_o
);

  localparam int SLOTS  = SECTOR_BYTES / ENTRY_BYTES;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

  logic [SLOT_W-1:0] slot_q, slot_d, slot_cur;
  logic [31:0]       offset_q, offset_d, offset_cur;
  logic              ended_q, ended_d, ended_cur;
  logic              accept;
  logic [31:0]       esec;
  logic [7:0]        name0;
  logic [7:0]        mask;
  logic              long_name, live, at_boundary;
  logic [31:0]       cluster;
  logic [3:0]        base_len;
  logic [1:0]        ext_len;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign name0      = name_base_i[7:0];
  assign long_name  = (attr_in_i == ATTR_LONG_NAME);
  assign live       = !long_name && (name0 != NAME_DELETED_A) && (name0 != NAME_DELETED_B);
  assign cluster    = {cluster_high_i, cluster_low_i};
  assign mask       = 8'((9'h1 << cluster_shift_i) - 9'h1);

  // restart puts this item at slot 0 of a fresh scan
  always_comb begin
    slot_cur   = restart_i ? '0 : slot_q;
    offset_cur = restart_i ? '0 : offset_q;
    ended_cur  = restart_i ? 1'b0 : ended_q;
  end

  assign esec        = root_sector_i + offset_cur;
  assign at_boundary = (((esec[7:0] + 8'd1) & mask) == 8'd0);

  // name lengths up to the first space
  always_comb begin
    base_len = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (name_base_i[8*i +: 8] == CHAR_SPACE) base_len = 4'(i);
    end
    ext_len = 2'd3;
    for (int i = 2; i >= 0; i--) begin
      if (name_ext_i[8*i +: 8] == CHAR_SPACE) ext_len = 2'(i);
    end
  end

  always_comb begin
    slot_d   = slot_q;
    offset_d = offset_q;
    ended_d  = ended_q;
    push_o   = 1'b0;
    job_o          = '0;
    job_o.esec     = esec;
    job_o.is_end   = 1'b1;
    if (accept) begin
      slot_d   = slot_cur;
      offset_d = offset_cur;
      ended_d  = ended_cur;
      if (ended_cur) begin
        push_o = 1'b1;
      end else if (!long_name && name0 == CHAR_NUL) begin
        ended_d = 1'b1;
        push_o  = 1'b1;
      end else begin
        if (slot_cur == SLOT_LAST) begin
          slot_d = '0;
          if (at_boundary) ended_d = 1'b1;
          else             offset_d = offset_cur + 32'd1;
        end else begin
          slot_d = slot_cur + SLOT_W'(1);
        end
        if (live) begin
          push_o         = 1'b1;
          job_o.is_end   = 1'b0;
          job_o.base     = name_base_i;
          job_o.ext      = name_ext_i;
          job_o.base_len = base_len;
          job_o.ext_len  = ext_len;
          job_o.attr     = attr_in_i;
          job_o.size     = file_bytes_i;
          job_o.start    = (cluster << cluster_shift_i) + root_sector_i
                         - ({4'd0, root_cluster_i} << cluster_shift_i);
        end else begin
          // skipped entry gives a result only when it closes the cluster
          push_o = ended_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      offset_q <= '0;
      ended_q  <= 1'b0;
    end else begin
      slot_q   <= slot_d;
      offset_q <= offset_d;
      ended_q  <= ended_d;
    end
  end

endmodule

### rtl/core/fds_queue.sv
`timescale 1ns / 1ps

module fds_queue import fds_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  output logic head_valid_o,
  output job_t head_o,
  input  logic pop_i
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o       = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = slots_q[rd_q];

  function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ptr_inc(wr_q);
      if (pop_i)  rd_q <= ptr_inc(rd_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + CNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

endmodule

### rtl/core/fds_back.sv
`timescale 1ns / 1ps

module fds_back import fds_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    head_valid_i,
  input  job_t    head_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t res_o
);

  logic [3:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  result_t    res_q, res_d;
  logic       load;
  logic [3:0] dot_pos;
  logic [3:0] ext_end;
  logic [3:0] ext_pos;

  assign load    = head_valid_i && (!vld_q || out_ready_i);
  assign dot_pos = head_i.base_len;
  assign ext_end = head_i.base_len + 4'd1 + {2'd0, head_i.ext_len};
  assign ext_pos = idx_q - head_i.base_len - 4'd1;

  // pick the character at the current position of the compacted name
  always_comb begin
    res_d        = '0;
    res_d.attr   = head_i.attr;
    res_d.start  = head_i.start;
    res_d.size   = head_i.size;
    res_d.esec   = head_i.esec;
    if (head_i.is_end) begin
      res_d        = '0;
      res_d.status = 1'b1;
      res_d.esec   = head_i.esec;
      res_d.last   = 1'b1;
    end else if (idx_q < head_i.base_len) begin
      res_d.name_char = head_i.base[8*idx_q[2:0] +: 8];
    end else if (head_i.ext_len != 2'd0 && idx_q == dot_pos) begin
      res_d.name_char = CHAR_DOT;
    end else if (head_i.ext_len != 2'd0 && idx_q < ext_end) begin
      res_d.name_char = head_i.ext[8*ext_pos[1:0] +: 8];
    end else begin
      res_d.name_char = CHAR_NUL;
      res_d.last      = 1'b1;
    end
  end

  assign pop_o = load && res_d.last;

  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    if (load) begin
      idx_d = res_d.last ? 4'd0 : idx_q + 4'd1;
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) res_q <= res_d;
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

### rtl/core/fat_directory_entry_scanner_unit.sv
`timescale 1ns / 1ps
// channel   signals                                     direction
// -------   -----------------------------------------   ---------
// entry     in_valid_i / in_ready_o, directory fields   in
// result    out_valid_o / out_ready_i, result fields    out
// config    cfg_we_i, cfg_index_i, cfg_data_i           in, write only
//
// the front takes one entry per cycle while the queue has room; skipped entries
// leave nothing in the queue unless they close the cluster; the back sequencer
// emits one result per cycle unless stalled: a live entry gives 1 to 13 results
// (name length + optional dot + extension + terminator), an end result 1
// reset clears scan position, end flag, queue pointers and the output valid
// either side may stall; a full queue holds off the entry channel

module fat_directory_entry_scanner_unit import fds_pkg::*; #(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  restart_i,
  input  logic [63:0]           name_base_i,
  input  logic [23:0]           name_ext_i,
  input  logic [7:0]            attr_in_i,
  input  logic [15:0]           cluster_high_i,
  input  logic [15:0]           cluster_low_i,
  input  logic [31:0]           file_bytes_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  status_o,
  output logic [7:0]            name_char_o,
  output logic [7:0]            attr_out_o,
  output logic [31:0]           start_sector_o,
  output logic [31:0]           size_out_o,
  output logic [31:0]           entry_sector_o,
  output logic                  last_o
);

  // configuration registers
  logic [2:0]  cluster_shift_q;
  logic [31:0] root_sector_q;
  logic [27:0] root_cluster_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cluster_shift_q <= '0;
      root_sector_q   <= '0;
      root_cluster_q  <= ROOT_CLUSTER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_CLUSTER_SHIFT:   cluster_shift_q <= cfg_data_i[2:0];
        CFG_ROOT_SECTOR:     root_sector_q   <= cfg_data_i;
        CFG_ROOT_CLUSTER_NR: root_cluster_q  <= cfg_data_i[27:0];
        default: ;
      endcase
    end
  end

  // front to queue
  logic    push;
  job_t    push_job;
  logic    full;
  // queue to back
  logic    head_valid;
  job_t    head;
  logic    pop;
  result_t res;

  fds_front #(
    .SECTOR_BYTES(SECTOR_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .restart_i      (restart_i),
    .name_base_i    (name_base_i),
    .name_ext_i     (name_ext_i),
    .attr_in_i      (attr_in_i),
    .cluster_high_i (cluster_high_i),
    .cluster_low_i  (cluster_low_i),
    .file_bytes_i   (file_bytes_i),
    .cluster_shift_i(cluster_shift_q),
    .root_sector_i  (root_sector_q),
    .root_cluster_i (root_cluster_q),
    .full_i         (full),
    .push_o         (push),
    .job_o          (push_job)
  );

  fds_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .job_i       (push_job),
    .full_o      (full),
    .head_valid_o(head_valid),
    .head_o      (head),
    .pop_i       (pop)
  );

  fds_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign status_o       = res.status;
  assign name_char_o    = res.name_char;
  assign attr_out_o     = res.attr;
  assign start_sector_o = res.start;
  assign size_out_o     = res.size;
  assign entry_sector_o = res.esec;
  assign last_o         = res.last;

  // the front never writes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("queue written while full");

  // the back only retires a job that is present
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> head_valid)
    else $error("queue popped while empty");

  // an end-of-directory result is a lone, last, empty result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o && name_char_o == CHAR_NUL && size_out_o == 32'd0)
    else $error("malformed end result");

  // the last result of a found entry is its terminator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o && !status_o |-> name_char_o == CHAR_NUL)
    else $error("name not terminated");

endmodule

### tb/fat_directory_entry_scanner_unit_tb.sv
`timescale 1ns / 1ps

module fat_directory_entry_scanner_unit_tb;
  import fds_pkg::*;

  localparam int SLOTS_PER_SECTOR = SECTOR_BYTES_DEF / ENTRY_BYTES;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int SETTLE_CYCLES    = 40;   // longest name plus queue depth, with margin
  localparam int HOLD_CYCLES      = 400;
  localparam int PHASE_ITEMS      = 71;

  // how a directed row is checked
  typedef enum logic [1:0] {ROW_MODEL, ROW_SILENT, ROW_END} row_check_e;
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // one directory entry as presented on the entry channel
  typedef struct packed {
    logic        restart;
    logic [63:0] base;
    logic [23:0] ext;
    logic [7:0]  attr;
    logic [15:0] clus_hi;
    logic [15:0] clus_lo;
    logic [31:0] size;
  } dir_entry_t;

  typedef struct packed {
    dir_entry_t  entry;
    row_check_e  check;
    logic [4:0]  reps;
    logic [31:0] end_sector;
  } dir_row_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  // block inputs, all known from time zero
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_CLUSTER_SHIFT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  restart = 1'b0;
  logic [63:0]           name_base = '0;
  logic [23:0]           name_ext = '0;
  logic [7:0]            attr_in = '0;
  logic [15:0]           cluster_high = '0;
  logic [15:0]           cluster_low = '0;
  logic [31:0]           file_bytes = '0;
  logic                  out_ready = 1'b0;

  // block outputs
  logic        in_ready_o;
  logic        out_valid_o;
  logic        status_o;
  logic [7:0]  name_char_o;
  logic [7:0]  attr_out_o;
  logic [31:0] start_sector_o;
  logic [31:0] size_out_o;
  logic [31:0] entry_sector_o;
  logic        last_o;

  fat_directory_entry_scanner_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .restart_i      (restart),
    .name_base_i    (name_base),
    .name_ext_i     (name_ext),
    .attr_in_i      (attr_in),
    .cluster_high_i (cluster_high),
    .cluster_low_i  (cluster_low),
    .file_bytes_i   (file_bytes),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .status_o       (status_o),
    .name_char_o    (name_char_o),
    .attr_out_o     (attr_out_o),
    .start_sector_o (start_sector_o),
    .size_out_o     (size_out_o),
    .entry_sector_o (entry_sector_o),
    .last_o         (last_o)
  );

  // mirror of the configuration registers
  logic [2:0]  cfg_shift = 3'd0;
  logic [31:0] cfg_root_sector = '0;
  logic [27:0] cfg_root_cluster = ROOT_CLUSTER_RESET;

  // mirror of the scan position
  int unsigned slot_nr = 0;
  logic [31:0] sector_off = '0;
  logic        scan_done = 1'b0;

  result_t     awaited_results[$];   // in transfer order, oldest first
  result_t     fresh_results[$];     // what the last accepted entry causes
  dir_row_t    directed_rows[$];

  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        long_hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // end-of-directory result for the given entry sector
  function automatic void queue_end_marker(input logic [31:0] esec);
    result_t r;
    r = '0;
    r.status = 1'b1;
    r.esec = esec;
    r.last = 1'b1;
    fresh_results.push_back(r);
  endfunction

  // walk one accepted entry through the scan and list the transfers it causes
  function automatic void scan_entry(input dir_entry_t e);
    logic [31:0] esec;
    logic [31:0] start_sec;
    logic [31:0] mask;
    logic [7:0]  ch;
    logic        live;
    result_t     r;
    if (e.restart) begin
      slot_nr = 0;
      sector_off = '0;
      scan_done = 1'b0;
    end
    esec = cfg_root_sector + sector_off;
    // once ended, every entry just reports the end again
    if (scan_done) begin
      queue_end_marker(esec);
      return;
    end
    // zero first byte ends the directory, unless it is a long-name slot
    if (e.attr != ATTR_LONG_NAME && e.base[7:0] == CHAR_NUL) begin
      scan_done = 1'b1;
      queue_end_marker(esec);
      return;
    end
    live = e.attr != ATTR_LONG_NAME && e.base[7:0] != NAME_DELETED_A &&
           e.base[7:0] != NAME_DELETED_B;
    // step to the next slot; leaving the last sector of a cluster ends the scan
    mask = (32'd1 << cfg_shift) - 32'd1;
    slot_nr++;
    if (slot_nr >= SLOTS_PER_SECTOR) begin
      slot_nr = 0;
      if (((esec + 32'd1) & mask) == '0) scan_done = 1'b1;
      else sector_off = sector_off + 32'd1;
    end
    if (!live) begin
      if (scan_done) queue_end_marker(cfg_root_sector + sector_off);
      return;
    end
    start_sec = ({e.clus_hi, e.clus_lo} << cfg_shift) + cfg_root_sector -
                ({4'd0, cfg_root_cluster} << cfg_shift);
    r = '0;
    r.attr = e.attr;
    r.start = start_sec;
    r.size = e.size;
    r.esec = esec;
    // base name up to the first space, then dot and extension
    for (int i = 0; i < 8; i++) begin
      ch = e.base[8*i +: 8];
      if (ch == CHAR_SPACE) break;
      r.name_char = ch;
      fresh_results.push_back(r);
    end
    if (e.ext[7:0] != CHAR_SPACE) begin
      r.name_char = CHAR_DOT;
      fresh_results.push_back(r);
    end
    for (int i = 0; i < 3; i++) begin
      ch = e.ext[8*i +: 8];
      if (ch == CHAR_SPACE) break;
      r.name_char = ch;
      fresh_results.push_back(r);
    end
    r.name_char = CHAR_NUL;
    r.last = 1'b1;
    fresh_results.push_back(r);
  endfunction

  // name text padded with spaces, first character in the low byte
  function automatic logic [63:0] pad_name(input string s);
    logic [63:0] v;
    v = {8{CHAR_SPACE}};
    for (int i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  // extension text padded with spaces, first character in the low byte
  function automatic logic [23:0] pad_ext(input string s);
    return 24'(pad_name(s));
  endfunction

  function automatic void add_row(input logic rs, input logic [63:0] base,
                                  input logic [23:0] ext, input logic [7:0] attr,
                                  input logic [15:0] hi, input logic [15:0] lo,
                                  input logic [31:0] size, input row_check_e check,
                                  input logic [4:0] reps, input logic [31:0] end_sec);
    dir_row_t row;
    row.entry = {rs, base, ext, attr, hi, lo, size};
    row.check = check;
    row.reps = reps;
    row.end_sector = end_sec;
    directed_rows.push_back(row);
  endfunction

  // mostly well-formed slots with random content, some noise
  function automatic dir_entry_t random_entry();
    dir_entry_t  e;
    int unsigned pick;
    int unsigned base_len;
    int unsigned ext_len;
    // after an end a restart comes soon, so scans get going again
    e.restart = scan_done ? 1'($urandom_range(1)) : ($urandom_range(99) < 3);
    e.base = {$urandom, $urandom};
    e.ext = 24'($urandom);
    e.attr = 8'($urandom);
    e.clus_hi = 16'($urandom);
    e.clus_lo = 16'($urandom);
    e.size = $urandom;
    pick = $urandom_range(99);
    if (pick < 65) begin
      // live entry, space padded name and extension
      base_len = $urandom_range(8);
      ext_len = $urandom_range(3);
      for (int i = 0; i < 8; i++)
        e.base[8*i +: 8] = (i < base_len) ? 8'($urandom_range(126, 33)) : CHAR_SPACE;
      for (int i = 0; i < 3; i++)
        e.ext[8*i +: 8] = (i < ext_len) ? 8'($urandom_range(126, 33)) : CHAR_SPACE;
      if (e.attr == ATTR_LONG_NAME) e.attr = 8'h20;
      if ($urandom_range(1)) e.clus_hi = '0;
    end else if (pick < 75) begin
      e.attr = ATTR_LONG_NAME;
      if ($urandom_range(1)) e.base[7:0] = CHAR_NUL;
    end else if (pick < 87) begin
      e.base[7:0] = $urandom_range(1) ? NAME_DELETED_A : NAME_DELETED_B;
    end else if (pick < 92) begin
      e.base[7:0] = CHAR_NUL;
      if (e.attr == ATTR_LONG_NAME) e.attr = 8'h00;
    end
    return e;
  endfunction

  // present one entry, wait for its transfer, then record what it causes
  task automatic offer_entry(input dir_entry_t e, input row_check_e check,
                             input logic [31:0] end_sec);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    restart <= e.restart;
    name_base <= e.base;
    name_ext <= e.ext;
    attr_in <= e.attr;
    cluster_high <= e.clus_hi;
    cluster_low <= e.clus_lo;
    file_bytes <= e.size;
    do @(posedge clk); while (!in_ready_o);
    scan_entry(e);
    if (check == ROW_MODEL) begin
      while (fresh_results.size() != 0) awaited_results.push_back(fresh_results.pop_front());
    end else begin
      // typed-in rows: nothing at all, or one end result at a known sector
      fresh_results.delete();
      if (check == ROW_END) begin
        queue_end_marker(end_sec);
        awaited_results.push_back(fresh_results.pop_front());
      end
    end
  endtask

  // stop offering until every awaited transfer is in, then let skipped work settle
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all three registers, only while the block is idle
  task automatic load_config(input logic [2:0] shift, input logic [31:0] root_sec,
                             input logic [27:0] root_clus);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CLUSTER_SHIFT;
    cfg_data <= {29'd0, shift};
    @(posedge clk);
    cfg_index <= CFG_ROOT_SECTOR;
    cfg_data <= root_sec;
    @(posedge clk);
    cfg_index <= CFG_ROOT_CLUSTER_NR;
    cfg_data <= {4'd0, root_clus};
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_shift = shift;
    cfg_root_sector = root_sec;
    cfg_root_cluster = root_clus;
  endtask

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        sender_idle_pct = 0;
        stall_pct = 0;
      end
      IDLE_SENDER: begin
        sender_idle_pct = 48;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct = 0;
        stall_pct = 48;
      end
      default: begin
        sender_idle_pct = 34;
        stall_pct = 34;
      end
    endcase
  endtask

  // one random phase under a fixed register setting
  task automatic run_phase(input logic [2:0] shift, input logic [31:0] root_sec,
                           input logic [27:0] root_clus, input idle_mode_e mode,
                           input logic with_hold);
    load_config(shift, root_sec, root_clus);
    set_idling(mode);
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // halfway the sender waits for the result side to empty
      if (n == PHASE_ITEMS / 2) drain_results();
      // receiver holds off while entries keep coming, so the queue fills
      if (with_hold && n == 10) long_hold_req = 1'b1;
      offer_entry(random_entry(), ROW_MODEL, '0);
    end
    drain_results();
  endtask

  function automatic void check_field(input string label, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      mismatches++;
    end
  endfunction

  // result side: compare each transfer with the oldest expectation, then pick ready
  always @(posedge clk) begin : result_port
    result_t want;
    if (out_valid_o && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0h char %0h",
                 $time, status_o, name_char_o);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", 32'(want.status), 32'(status_o));
        check_field("name_char", 32'(want.name_char), 32'(name_char_o));
        check_field("attr_out", 32'(want.attr), 32'(attr_out_o));
        check_field("start_sector", want.start, start_sector_o);
        check_field("size_out", want.size, size_out_o);
        check_field("entry_sector", want.esec, entry_sector_o);
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fat_directory_entry_scanner_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    // directed table at the reset register values: one sector per cluster, root at 0
    add_row(1'b1, pad_name("README"), pad_ext("TXT"), 8'h20, 16'h0000, 16'h0005,
            32'd1234, ROW_MODEL, 5'd1, '0);
    // long-name slot with zero first byte is skipped, scan goes on
    add_row(1'b0, 64'd0, 24'd0, ATTR_LONG_NAME, 16'h1234, 16'h5678, 32'd9,
            ROW_SILENT, 5'd1, '0);
    // deleted entries, both markers
    add_row(1'b0, {pad_name("ABC")} & ~64'hff | {56'd0, NAME_DELETED_B},
            pad_ext("DAT"), 8'h20, 16'h0, 16'h7, 32'd1, ROW_SILENT, 5'd1, '0);
    add_row(1'b0, {pad_name("ABC")} & ~64'hff | {56'd0, NAME_DELETED_A},
            pad_ext("DAT"), 8'h20, 16'h0, 16'h7, 32'd1, ROW_SILENT, 5'd1, '0);
    // all ones: longest name, largest cluster and size
    add_row(1'b0, '1, '1, 8'hff, 16'hffff, 16'hffff, 32'hffff_ffff,
            ROW_MODEL, 5'd1, '0);
    // blank name and extension: terminator only
    add_row(1'b0, pad_name(""), pad_ext(""), 8'h00, 16'h0, 16'h0, 32'd0,
            ROW_MODEL, 5'd1, '0);
    // extension starting with a space: no dot
    add_row(1'b0, pad_name("A"), pad_ext(" XY"), 8'h10, 16'h0fff, 16'hffff,
            32'd77, ROW_MODEL, 5'd1, '0);
    // embedded zero byte is copied as a character
    add_row(1'b0, 64'h2020_2020_2042_0041, pad_ext("C"), 8'h01, 16'h0, 16'h2,
            32'd5, ROW_MODEL, 5'd1, '0);
    // zero first byte ends the directory
    add_row(1'b0, 64'd0, pad_ext("EXE"), 8'h20, 16'h0, 16'h9, 32'd3,
            ROW_END, 5'd1, 32'd0);
    // entry after the end
    add_row(1'b0, pad_name("LATE"), pad_ext("TXT"), 8'h20, 16'h0, 16'h9, 32'd3,
            ROW_END, 5'd1, 32'd0);
    // restart on a long-name slot, then fill all but the last slot of the sector with deleted slots
    add_row(1'b1, 64'd0, 24'd0, ATTR_LONG_NAME, 16'h0, 16'h0, 32'd0,
            ROW_SILENT, 5'd1, '0);
    add_row(1'b0, pad_name("X") & ~64'hff | {56'd0, NAME_DELETED_B}, pad_ext(""),
            8'h20, 16'h0, 16'h3, 32'd0, ROW_SILENT, 5'd14, '0);
    // skipped last slot of the cluster: end right away
    add_row(1'b0, pad_name("X") & ~64'hff | {56'd0, NAME_DELETED_B}, pad_ext(""),
            8'h20, 16'h0, 16'h3, 32'd0, ROW_END, 5'd1, 32'd0);
    add_row(1'b0, pad_name("NEXT"), pad_ext("DOC"), 8'h20, 16'h0, 16'h4, 32'd8,
            ROW_END, 5'd1, 32'd0);
    // live last slot of the cluster: name first, end on the following entry
    add_row(1'b1, pad_name("X") & ~64'hff | {56'd0, NAME_DELETED_A}, pad_ext(""),
            8'h20, 16'h0, 16'h3, 32'd0, ROW_SILENT, 5'd1, '0);
    add_row(1'b0, pad_name("X") & ~64'hff | {56'd0, NAME_DELETED_A}, pad_ext(""),
            8'h20, 16'h0, 16'h3, 32'd0, ROW_SILENT, 5'd14, '0);
    add_row(1'b0, pad_name("LAST"), pad_ext("BIN"), 8'h04, 16'h0002, 16'h0010,
            32'd4096, ROW_MODEL, 5'd1, '0);
    add_row(1'b0, pad_name("AFTER"), pad_ext("BIN"), 8'h20, 16'h0, 16'h11, 32'd2,
            ROW_END, 5'd1, 32'd0);
    // root cluster itself maps to the root sector
    add_row(1'b1, pad_name("ROOT"), pad_ext("D"), 8'h10, 16'h0, 16'h2, 32'd0,
            ROW_MODEL, 5'd1, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(IDLE_NONE);
    foreach (directed_rows[i])
      repeat (directed_rows[i].reps)
        offer_entry(directed_rows[i].entry, directed_rows[i].check,
                    directed_rows[i].end_sector);
    drain_results();

    // random phases across register settings and idling patterns
    run_phase(3'd3, 32'd1000, 28'd2, IDLE_NONE, 1'b1);
    run_phase(3'd7, 32'hffff_ffff, 28'h0fff_ffff, IDLE_SENDER, 1'b0);
    run_phase(3'd1, 32'hffff_fff0, 28'd0, IDLE_RECEIVER, 1'b0);
    run_phase(3'd2, $urandom, 28'($urandom), IDLE_BOTH, 1'b0);
    run_phase(3'd0, 32'h8000_0000, 28'd1, IDLE_BOTH, 1'b0);
    run_phase(3'd4, 32'd7, 28'd3, IDLE_NONE, 1'b0);

    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("fat_directory_entry_scanner_unit_tb: done, clean");
    end else begin
      $display("fat_directory_entry_scanner_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
